FILE: sv/mrpt_pkg.sv
// ----------------------------------------------------------------------------
// Miller-Rabin test unit package
// Microcode word layout, step addresses and the control program of the
// sequencer that runs one Miller-Rabin round per request.
// ----------------------------------------------------------------------------
package mrpt_pkg;

  localparam int FIELD_W = 64;

  typedef logic [4:0] upc_t;

  typedef enum logic [3:0] {
    UOP_NONE,
    UOP_LOAD,
    UOP_INIT,
    UOP_STRIP,
    UOP_CALL_RED,
    UOP_SET_BASE,
    UOP_CALL_MUL,
    UOP_SET_X,
    UOP_CALL_SQ,
    UOP_SET_SQ,
    UOP_CALL_XX,
    UOP_SET_X_DEC,
    UOP_FAIL,
    UOP_PASS,
    UOP_DBL,
    UOP_ADD
  } uop_t;

  typedef enum logic [3:0] {
    CND_ALWAYS,
    CND_NO_REQ,
    CND_N_LT2,
    CND_N_EQ2,
    CND_N_EVEN,
    CND_D_EVEN,
    CND_ACC_ZERO,
    CND_E_ZERO,
    CND_E_EVEN,
    CND_X_TRIV,
    CND_R_ONE,
    CND_ACC_NM1,
    CND_X_ONE,
    CND_OUT_BUSY,
    CND_BITS_DONE
  } cnd_t;

  typedef struct packed {
    uop_t op;
    cnd_t cnd;
    upc_t nxt_t;
    upc_t nxt_f;
    logic ret_sel;
  } uword_t;

  localparam upc_t U_IDLE    = 5'd0;
  localparam upc_t U_LT2     = 5'd1;
  localparam upc_t U_EQ2     = 5'd2;
  localparam upc_t U_INIT    = 5'd3;
  localparam upc_t U_STRIP   = 5'd4;
  localparam upc_t U_RED     = 5'd5;
  localparam upc_t U_BASE    = 5'd6;
  localparam upc_t U_PW_TEST = 5'd7;
  localparam upc_t U_PW_ODD  = 5'd8;
  localparam upc_t U_PW_MUL  = 5'd9;
  localparam upc_t U_PW_MST  = 5'd10;
  localparam upc_t U_PW_SQ   = 5'd11;
  localparam upc_t U_PW_SST  = 5'd12;
  localparam upc_t U_XCHK    = 5'd13;
  localparam upc_t U_SQ_TEST = 5'd14;
  localparam upc_t U_SQ_MUL  = 5'd15;
  localparam upc_t U_SQ_ST   = 5'd16;
  localparam upc_t U_SQ_ONE  = 5'd17;
  localparam upc_t U_FAIL    = 5'd18;
  localparam upc_t U_PASS    = 5'd19;
  localparam upc_t U_M_DBL   = 5'd20;
  localparam upc_t U_M_ADD   = 5'd21;

  // Control store. A call word branches to the multiply routine and leaves
  // its false target as the return address.
  function automatic uword_t mrpt_ucode(input upc_t pc);
    uword_t w;
    case (pc)
      U_IDLE:    w = '{UOP_LOAD,      CND_NO_REQ,    U_IDLE,    U_LT2,     1'b0};
      U_LT2:     w = '{UOP_NONE,      CND_N_LT2,     U_FAIL,    U_EQ2,     1'b0};
      U_EQ2:     w = '{UOP_NONE,      CND_N_EQ2,     U_PASS,    U_INIT,    1'b0};
      U_INIT:    w = '{UOP_INIT,      CND_N_EVEN,    U_FAIL,    U_STRIP,   1'b0};
      U_STRIP:   w = '{UOP_STRIP,     CND_D_EVEN,    U_STRIP,   U_RED,     1'b0};
      U_RED:     w = '{UOP_CALL_RED,  CND_ALWAYS,    U_M_DBL,   U_BASE,    1'b0};
      U_BASE:    w = '{UOP_SET_BASE,  CND_ACC_ZERO,  U_PASS,    U_PW_TEST, 1'b0};
      U_PW_TEST: w = '{UOP_NONE,      CND_E_ZERO,    U_XCHK,    U_PW_ODD,  1'b0};
      U_PW_ODD:  w = '{UOP_NONE,      CND_E_EVEN,    U_PW_SQ,   U_PW_MUL,  1'b0};
      U_PW_MUL:  w = '{UOP_CALL_MUL,  CND_ALWAYS,    U_M_DBL,   U_PW_MST,  1'b0};
      U_PW_MST:  w = '{UOP_SET_X,     CND_ALWAYS,    U_PW_SQ,   U_PW_SQ,   1'b0};
      U_PW_SQ:   w = '{UOP_CALL_SQ,   CND_ALWAYS,    U_M_DBL,   U_PW_SST,  1'b0};
      U_PW_SST:  w = '{UOP_SET_SQ,    CND_ALWAYS,    U_PW_TEST, U_PW_TEST, 1'b0};
      U_XCHK:    w = '{UOP_NONE,      CND_X_TRIV,    U_PASS,    U_SQ_TEST, 1'b0};
      U_SQ_TEST: w = '{UOP_NONE,      CND_R_ONE,     U_FAIL,    U_SQ_MUL,  1'b0};
      U_SQ_MUL:  w = '{UOP_CALL_XX,   CND_ALWAYS,    U_M_DBL,   U_SQ_ST,   1'b0};
      U_SQ_ST:   w = '{UOP_SET_X_DEC, CND_ACC_NM1,   U_PASS,    U_SQ_ONE,  1'b0};
      U_SQ_ONE:  w = '{UOP_NONE,      CND_X_ONE,     U_FAIL,    U_SQ_TEST, 1'b0};
      U_FAIL:    w = '{UOP_FAIL,      CND_OUT_BUSY,  U_FAIL,    U_IDLE,    1'b0};
      U_PASS:    w = '{UOP_PASS,      CND_OUT_BUSY,  U_PASS,    U_IDLE,    1'b0};
      U_M_DBL:   w = '{UOP_DBL,       CND_ALWAYS,    U_M_ADD,   U_M_ADD,   1'b0};
      U_M_ADD:   w = '{UOP_ADD,       CND_BITS_DONE, U_M_ADD,   U_M_DBL,   1'b1};
      default:   w = '{UOP_NONE,      CND_ALWAYS,    U_IDLE,    U_IDLE,    1'b0};
    endcase
    return w;
  endfunction

endpackage

FILE: sv/miller_rabin_primality_test_unit.sv
// ----------------------------------------------------------------------------
// Miller-Rabin primality test unit
// Runs one Miller-Rabin round per request on a microcoded modular datapath
// and reports a verdict for each run of rounds.
// ----------------------------------------------------------------------------
// Usage:
// Each request on the slave stream carries a candidate and a witness in
// tdata; tlast marks the final round of a run. A failed round sets a sticky
// mark. The request with tlast produces one result on the master stream:
// bit 0 of tdata is 1 if every round of the run passed, and the mark clears.
// Only the low WIDTH bits of candidate and witness are used.
// The unit takes one request at a time. A modular product runs the call step,
// one doubling and one conditional add per multiplier bit, MSB first, and
// the store step. A round costs the witness reduction (one product), up to
// two products per bit of the odd exponent and up to one squaring per
// stripped factor of two; candidates below two, equal to two or even need no
// product.
// tready is high only while the sequencer waits for a request. A result is
// held in an output register until taken; the next request is accepted while
// it waits, and only a further final verdict waits for it to drain.
// rst clears the sequencer, the sticky mark and the output valid.
// ----------------------------------------------------------------------------
module miller_rabin_primality_test_unit #(
  parameter int WIDTH = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // candidate [63:0], witness [127:64]
  input  logic [2*mrpt_pkg::FIELD_W-1:0] s_axis_tdata,
  // last_witness
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // probable_prime [0], zero fill [7:1]
  output logic [7:0]                     m_axis_tdata
);
  import mrpt_pkg::*;

  localparam int CW = $clog2(WIDTH);

  upc_t             pc;
  upc_t             pc_next;
  upc_t             ret;
  uword_t           uw;
  logic             cnd_true;
  logic             out_busy;

  logic [WIDTH-1:0] n;
  logic [WIDTH-1:0] a;
  logic [WIDTH-1:0] nm1;
  logic [WIDTH-1:0] d;
  logic [WIDTH-1:0] e;
  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] mop;
  logic [WIDTH-1:0] mad;
  logic [WIDTH-1:0] x;
  logic [WIDTH-1:0] sq;
  logic [CW-1:0]    rcnt;
  logic [CW-1:0]    bcnt;
  logic             last;
  logic             failed;
  logic             fail_all;
  logic             out_valid;
  logic             out_prime;

  logic [WIDTH:0]   red_sum;
  logic [WIDTH+1:0] red_diff;
  logic [WIDTH-1:0] red_res;

  assign uw            = mrpt_ucode(pc);
  assign s_axis_tready = (uw.op == UOP_LOAD);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'b0, out_prime};
  assign out_busy      = last && out_valid && !m_axis_tready;
  assign fail_all      = failed || (uw.op == UOP_FAIL);

  always_comb begin
    if (uw.op == UOP_DBL) begin
      red_sum = {acc, 1'b0};
    end else if (mop[WIDTH-1]) begin
      red_sum = {1'b0, acc} + {1'b0, mad};
    end else begin
      red_sum = {1'b0, acc};
    end
    red_diff = {1'b0, red_sum} - {2'b00, n};
    red_res  = red_diff[WIDTH+1] ? red_sum[WIDTH-1:0] : red_diff[WIDTH-1:0];
  end

  always_comb begin
    case (uw.cnd)
      CND_ALWAYS:    cnd_true = 1'b1;
      CND_NO_REQ:    cnd_true = !s_axis_tvalid;
      CND_N_LT2:     cnd_true = (n[WIDTH-1:1] == '0);
      CND_N_EQ2:     cnd_true = (n == WIDTH'(2));
      CND_N_EVEN:    cnd_true = !n[0];
      CND_D_EVEN:    cnd_true = !d[0];
      CND_ACC_ZERO:  cnd_true = (acc == '0);
      CND_E_ZERO:    cnd_true = (e == '0);
      CND_E_EVEN:    cnd_true = !e[0];
      CND_X_TRIV:    cnd_true = (x == WIDTH'(1)) || (x == nm1);
      CND_R_ONE:     cnd_true = (rcnt == CW'(1));
      CND_ACC_NM1:   cnd_true = (acc == nm1);
      CND_X_ONE:     cnd_true = (x == WIDTH'(1));
      CND_OUT_BUSY:  cnd_true = out_busy;
      CND_BITS_DONE: cnd_true = (bcnt == '0);
      default:       cnd_true = 1'b0;
    endcase
    if (cnd_true) begin
      pc_next = uw.ret_sel ? ret : uw.nxt_t;
    end else begin
      pc_next = uw.nxt_f;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= U_IDLE;
      failed    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pc <= pc_next;
      if ((uw.op == UOP_FAIL || uw.op == UOP_PASS) && !out_busy && last) begin
        out_valid <= 1'b1;
        out_prime <= !fail_all;
        failed    <= 1'b0;
      end else begin
        if (out_valid && m_axis_tready) begin
          out_valid <= 1'b0;
        end
        if ((uw.op == UOP_FAIL || uw.op == UOP_PASS) && !last) begin
          failed <= fail_all;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (uw.op)
      UOP_LOAD: begin
        if (s_axis_tvalid) begin
          n    <= s_axis_tdata[WIDTH-1:0];
          a    <= s_axis_tdata[FIELD_W +: WIDTH];
          last <= s_axis_tlast;
        end
      end
      UOP_INIT: begin
        nm1  <= n - WIDTH'(1);
        d    <= n - WIDTH'(1);
        rcnt <= '0;
      end
      UOP_STRIP: begin
        if (!d[0]) begin
          d    <= d >> 1;
          rcnt <= rcnt + CW'(1);
        end
      end
      UOP_CALL_RED: begin
        mop  <= a;
        mad  <= WIDTH'(1);
        acc  <= '0;
        bcnt <= CW'(WIDTH - 1);
        ret  <= uw.nxt_f;
      end
      UOP_SET_BASE: begin
        sq <= acc;
        x  <= WIDTH'(1);
        e  <= d;
      end
      UOP_CALL_MUL: begin
        mop  <= sq;
        mad  <= x;
        acc  <= '0;
        bcnt <= CW'(WIDTH - 1);
        ret  <= uw.nxt_f;
      end
      UOP_SET_X: begin
        x <= acc;
      end
      UOP_CALL_SQ: begin
        mop  <= sq;
        mad  <= sq;
        acc  <= '0;
        bcnt <= CW'(WIDTH - 1);
        ret  <= uw.nxt_f;
      end
      UOP_SET_SQ: begin
        sq <= acc;
        e  <= e >> 1;
      end
      UOP_CALL_XX: begin
        mop  <= x;
        mad  <= x;
        acc  <= '0;
        bcnt <= CW'(WIDTH - 1);
        ret  <= uw.nxt_f;
      end
      UOP_SET_X_DEC: begin
        x    <= acc;
        rcnt <= rcnt - CW'(1);
      end
      UOP_DBL: begin
        acc <= red_res;
      end
      UOP_ADD: begin
        acc  <= red_res;
        mop  <= mop << 1;
        bcnt <= bcnt - CW'(1);
      end
      default: begin
      end
    endcase
  end

endmodule
